@@ hdl/skl_pkg.sv @@
// ----------------------------------------------------------------------------
// skl_pkg
// Shared types and constants for the streaming k-th largest unit: the input
// and output transaction payloads and the links between the sorted cells.
// ----------------------------------------------------------------------------
package skl_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 5;

    // Input transaction payload
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_of_set;
    } in_item_t;

    // Output transaction payload
    typedef struct packed {
        logic signed [VALUE_W-1:0] kth_value;
        logic                      set_short;
    } out_item_t;

    // What a cell hands to its lower neighbor
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;  // value held by the cell
        logic                      valid;  // cell holds a kept value
        logic                      ins;    // new value ranks at or above it
    } skl_link_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic shift_en;  // a new value is taken in this cycle
        logic clear;     // empty the store after a set closes
        logic keep;      // cell index is below the effective rank
    } skl_cell_ctrl_t;

endpackage

@@ hdl/streaming_kth_largest_unit.sv @@
// ----------------------------------------------------------------------------
// streaming_kth_largest_unit
// Keeps the k largest values of the current set in a chain of sorted cells
// and reports the k-th largest when the set closes.
// ----------------------------------------------------------------------------
// Usage: one value is taken per cycle while input ready is high; each value
// is inserted into a row of MAX_RANK sorted cells in the cycle it is
// accepted. Once a transaction marked last_of_set is accepted, input ready
// stays low while the tail of the chain is read into the output register
// and the store is emptied, after any waiting result is taken. rank_k is
// clamped to 1..MAX_RANK; write it only while the unit is idle. When the set
// held fewer than k values, the smallest value seen is reported and
// set_short is raised.
module streaming_kth_largest_unit #(
    parameter int MAX_RANK = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [skl_pkg::RANK_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  skl_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output skl_pkg::out_item_t          out_data
);
    import skl_pkg::*;

    localparam int KW = ($clog2(MAX_RANK + 1) > RANK_W) ? $clog2(MAX_RANK + 1) : RANK_W;

    logic [RANK_W-1:0]   rank_k_reg;
    logic [KW-1:0]       rank_ext;
    logic [KW-1:0]       k_eff;
    logic                pend_reg;
    logic                pend_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_data_reg;
    out_item_t           out_data_next;
    logic                accept;
    logic                close;
    logic [MAX_RANK-1:0] keep;
    logic [MAX_RANK-1:0] tail;
    logic [MAX_RANK-1:0] boundary;
    logic signed [VALUE_W-1:0] tail_value;
    logic                full;
    skl_link_t           link [MAX_RANK+1];

    // Rank register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_k_reg <= RANK_W'(1);
        end
        else if (cfg_wr_en)
        begin
            rank_k_reg <= cfg_wr_data;
        end
    end

    // Effective rank, clamped to 1..MAX_RANK
    assign rank_ext = KW'(rank_k_reg);
    always_comb
    begin
        priority if (rank_ext == '0)
        begin
            k_eff = KW'(1);
        end
        else if (rank_ext > KW'(MAX_RANK))
        begin
            k_eff = KW'(MAX_RANK);
        end
        else
        begin
            k_eff = rank_ext;
        end
    end

    // Handshake
    assign in_ready = !pend_reg;
    assign accept   = in_valid && in_ready;
    assign close    = pend_reg && (!out_valid_reg || out_ready);

    // Head of the chain: a full slot that never yields
    assign link[0].value = '0;
    assign link[0].valid = 1'b1;
    assign link[0].ins   = 1'b0;

    // Row of sorted cells
    for (genvar i = 0; i < MAX_RANK; i++)
    begin : g_cell
        skl_cell_ctrl_t ctrl;

        assign keep[i]       = (KW'(i) < k_eff);
        assign ctrl.shift_en = accept;
        assign ctrl.clear    = close;
        assign ctrl.keep     = keep[i];

        skl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_value (in_data.value),
            .prev      (link[i]),
            .self      (link[i+1])
        );
    end

    // Tail of the kept values and the rank boundary
    for (genvar i = 0; i < MAX_RANK; i++)
    begin : g_tail
        if (i == MAX_RANK - 1)
        begin : g_end
            assign tail[i]     = link[i+1].valid && keep[i];
            assign boundary[i] = keep[i];
        end
        else
        begin : g_mid
            assign tail[i]     = link[i+1].valid && keep[i]
                                 && !(link[i+2].valid && keep[i+1]);
            assign boundary[i] = keep[i] && !keep[i+1];
        end
    end

    // AND-OR select of the tail value
    always_comb
    begin
        tail_value = '0;
        full       = 1'b0;
        for (int i = 0; i < MAX_RANK; i++)
        begin
            tail_value = tail_value | (link[i+1].value & {VALUE_W{tail[i]}});
            full       = full | (link[i+1].valid && boundary[i]);
        end
    end

    // Close and output control
    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        priority if (close)
        begin
            pend_next               = 1'b0;
            out_valid_next          = 1'b1;
            out_data_next.kth_value = tail_value;
            out_data_next.set_short = !full;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_next = 1'b0;
            end
            if (accept && in_data.last_of_set)
            begin
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/skl_cell.sv @@
// ----------------------------------------------------------------------------
// skl_cell
// One slot of the descending sorted store. Compares the broadcast value with
// its own, and either keeps its value, takes the new one, or takes the value
// shifted down from the cell above; a clear or a rank cut empties the slot.
// ----------------------------------------------------------------------------
module skl_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  skl_pkg::skl_cell_ctrl_t            ctrl,
    input  logic signed [skl_pkg::VALUE_W-1:0] new_value,
    input  skl_pkg::skl_link_t                 prev,
    output skl_pkg::skl_link_t                 self
);
    import skl_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      ins;

    // New value goes at or above this slot: empty slot, or strictly greater
    assign ins = !valid_reg || ($signed(new_value) > $signed(value_reg));

    assign self.value = value_reg;
    assign self.valid = valid_reg;
    assign self.ins   = ins;

    // Next slot contents
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift_en)
        begin
            if (!ctrl.keep)
            begin
                // beyond the rank: cut from the store
                valid_next = 1'b0;
            end
            else
            begin
                if (ins)
                begin
                    value_next = prev.ins ? prev.value : new_value;
                end
                valid_next = valid_reg | prev.valid;
            end
        end
        else
        begin
            // no transaction this cycle: slot holds
            valid_next = valid_reg;
        end
    end

    // Slot payload, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

@@ tb/sv/skl_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_result_checker
// Watches the register port and both channels of the k-th largest unit. It
// keeps its own sorted store per set, forms the expected result whenever a
// set closes, and compares every result transaction against the oldest one.
// ----------------------------------------------------------------------------
module skl_result_checker #(
    parameter int MAX_RANK = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [skl_pkg::RANK_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  skl_pkg::in_item_t           in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  skl_pkg::out_item_t          out_data,
    output int                          pending_results,
    output int                          mismatch_count
);

    import skl_pkg::*;

    localparam int PRINT_LIMIT = 40;

    // Shadow of the rank register and of the sorted store
    logic [RANK_W-1:0]          rank_reg = RANK_W'(1);
    logic signed [VALUE_W-1:0]  kept_vals [MAX_RANK];
    int                         kept_num = 0;
    out_item_t                  expected_kth_q [$];
    int                         errors = 0;

    assign mismatch_count = errors;

    // Rank 0 acts as 1, anything above the store depth as the depth
    function automatic int effective_rank(input logic [RANK_W-1:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > MAX_RANK)
            return MAX_RANK;
        return int'(r);
    endfunction

    // Insert one value into the descending store, holding at most k entries
    function automatic void keep_value(input logic signed [VALUE_W-1:0] v, input int k);
        int p;
        // rank may have dropped since the last insert: cut the store first
        if (kept_num > k)
            kept_num = k;
        if (kept_num < k)
        begin
            p = kept_num;
            kept_num++;
        end
        else
        begin
            // full: only a value above the smallest kept one gets in
            if (!(v > kept_vals[k-1]))
                return;
            p = k - 1;
        end
        while (p > 0 && v > kept_vals[p-1])
        begin
            kept_vals[p] = kept_vals[p-1];
            p--;
        end
        kept_vals[p] = v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    // Track configuration, results and accepted values at each edge
    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t exp_item;
        int        k;
        if (!rst_n)
        begin
            rank_reg = RANK_W'(1);
            kept_num = 0;
            expected_kth_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                rank_reg = cfg_wr_data;

            // result side first: a set closing at this edge cannot be out yet
            if (out_valid && out_ready)
            begin
                if (expected_kth_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d/%0b with no closed set waiting",
                                              out_data.kth_value, out_data.set_short));
                end
                else
                begin
                    exp_item = expected_kth_q.pop_front();
                    if (out_data.kth_value !== exp_item.kth_value)
                        report_mismatch($sformatf("kth_value got %0d expected %0d",
                                                  out_data.kth_value, exp_item.kth_value));
                    if (out_data.set_short !== exp_item.set_short)
                        report_mismatch($sformatf("set_short got %0b expected %0b",
                                                  out_data.set_short, exp_item.set_short));
                end
            end

            if (in_valid && in_ready)
            begin
                k = effective_rank(rank_reg);
                keep_value(in_data.value, k);
                if (in_data.last_of_set)
                begin
                    // short set reports its smallest value and raises the flag
                    if (kept_num >= k)
                    begin
                        exp_item.kth_value = kept_vals[k-1];
                        exp_item.set_short = 1'b0;
                    end
                    else
                    begin
                        exp_item.kth_value = kept_vals[kept_num-1];
                        exp_item.set_short = 1'b1;
                    end
                    expected_kth_q.push_back(exp_item);
                    kept_num = 0;
                end
            end

            pending_results <= expected_kth_q.size();
        end
    end

endmodule

@@ tb/sv/tb_streaming_kth_largest_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_streaming_kth_largest_unit
// Drives sets of signed values into the k-th largest unit under a range of
// rank settings, with bursty input and a stalling result side. A directed
// opening covers field extremes, rank clamping, equal values, short sets and
// a rank cut in the middle of a set; random phases follow. The checker
// beside the unit predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_streaming_kth_largest_unit;

    import skl_pkg::*;

    localparam int MAX_RANK     = 16;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 1750;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [RANK_W-1:0]  cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    in_item_t           in_data     = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    out_item_t          out_data;

    int pending_results;
    int mismatch_count;
    int cycle_count = 0;

    // Sender state
    int                 burst_left     = 0;
    int                 gap_left       = 0;
    bit                 sender_holding = 1'b0;
    int                 items_sent     = 0;
    int                 set_left       = 0;
    logic [RANK_W-1:0]  cur_rank       = RANK_W'(1);

    // Receiver stall pattern state
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          period     = 2;

    always #1 clk = ~clk;

    streaming_kth_largest_unit #(
        .MAX_RANK(MAX_RANK)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    skl_result_checker #(
        .MAX_RANK(MAX_RANK)
    ) kth_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .pending_results(pending_results),
        .mismatch_count (mismatch_count)
    );

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side stalls: a mode is held for a random stretch, then changes
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 200);
            period     = $urandom_range(2, 12);
        end
        mode_left--;
        case (ready_mode)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
            default:        out_ready <= ((mode_left % period) < (period + 1) / 2);
        endcase
    end

    // Pick the next burst length and the gap that follows it
    task automatic pick_burst();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            burst_left = $urandom_range(1, 8);
        else if (sel < 80)
            burst_left = $urandom_range(9, 20);
        else
            burst_left = $urandom_range(21, 60);
        sel = $urandom_range(0, 99);
        if (sel < 25)
            gap_left = 0;
        else if (sel < 90)
            gap_left = $urandom_range(1, 4);
        else
            gap_left = $urandom_range(5, 20);
    endtask

    // Offer one transaction and wait for it to be taken
    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic last);
        while (gap_left > 0)
        begin
            @(posedge clk);
            gap_left--;
        end
        in_valid       <= 1'b1;
        in_data        <= '{value: v, last_of_set: last};
        sender_holding  = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            pick_burst();
            if (gap_left > 0)
            begin
                in_valid       <= 1'b0;
                sender_holding  = 1'b0;
            end
        end
    endtask

    // Drop valid, then wait until every closed set has reported
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        if (sender_holding)
        begin
            in_valid       <= 1'b0;
            sender_holding  = 1'b0;
        end
        while (quiet < DRAIN_CYCLES)
        begin
            @(posedge clk);
            if (pending_results == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic write_rank(input logic [RANK_W-1:0] r);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        cur_rank     = r;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Value mix: full range, a narrow band for ties, and the extremes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return $urandom;
        if (sel < 75)
            return $urandom_range(0, 8) - 4;
        if (sel < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (sel < 92)
            return VAL_MAX - $urandom_range(0, 3);
        return VAL_MIN + $urandom_range(0, 3);
    endfunction

    // Set lengths cluster around the current rank so short and full sets mix
    function automatic int pick_set_len();
        int k;
        int sel;
        k   = (cur_rank == '0) ? 1 : ((int'(cur_rank) > MAX_RANK) ? MAX_RANK : int'(cur_rank));
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return $urandom_range(1, k + 2);
        if (sel < 80)
            return $urandom_range(k, k + 12);
        return $urandom_range(1, 48);
    endfunction

    // Stream n values; a set left open carries over into the next phase
    task automatic send_stream(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (set_left == 0)
                set_left = pick_set_len();
            set_left--;
            send_item(pick_value(), set_left == 0);
        end
    endtask

    initial
    begin : stimulus
        int                 phase_items;
        int                 sel;
        logic [RANK_W-1:0]  r;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        pick_burst();

        // reset rank picks the maximum, across both extremes
        send_item(-5, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b1);

        // rank zero behaves as one; single-value set
        write_rank('0);
        send_item(VAL_MIN, 1'b1);

        // short set at full depth
        write_rank(RANK_W'(MAX_RANK));
        send_item(10, 1'b0);
        send_item(-20, 1'b0);
        send_item(0, 1'b1);

        // rank above the depth is clamped; short set again
        write_rank('1);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b1);

        // ties with the smallest kept value
        write_rank(RANK_W'(3));
        send_item(4, 1'b0);
        send_item(4, 1'b0);
        send_item(4, 1'b0);
        send_item(4, 1'b0);
        send_item(2, 1'b0);
        send_item(4, 1'b1);

        // rank lowered while a set is open: store is cut before the next value
        write_rank(RANK_W'(4));
        send_item(1, 1'b0);
        send_item(8, 1'b0);
        send_item(6, 1'b0);
        send_item(3, 1'b0);
        write_rank(RANK_W'(2));
        send_item(-1, 1'b1);

        // random phases, each under a new rank setting
        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       r = '0;
                1:       r = RANK_W'(1);
                2:       r = RANK_W'(MAX_RANK);
                3:       r = '1;
                4:       r = RANK_W'($urandom_range(MAX_RANK + 1, 31));
                default: r = RANK_W'($urandom_range(1, MAX_RANK));
            endcase
            write_rank(r);
            phase_items = $urandom_range(20, 160);
            send_stream(phase_items);
        end

        // close the set still open so its result is checked too
        if (set_left > 0)
            send_stream(set_left);
        wait_idle();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
